// ===== hdl/i2cfb_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cfb_pkg
// Shared types and constants for the I2C slave frame buffer: item field
// widths, host action codes, bus status codes and the result flag group.
// ----------------------------------------------------------------------------
package i2cfb_pkg;

  // Item field widths
  localparam int ACTION_W   = 2;
  localparam int BYTE_W     = 8;
  localparam int HOST_IDX_W = 6;

  // Stream data widths (input 30 bits used, output 20 bits used)
  localparam int S_TDATA_W = 32;
  localparam int M_TDATA_W = 24;

  // Header layout
  localparam int unsigned HDR_BYTES = 2;

  // Width used for the frame end compare (pointer and length plus header)
  localparam int CMP_W = 10;

  // What an input item asks for
  typedef enum logic [ACTION_W-1:0] {
    ACT_BUS_EVENT  = 2'd0,
    ACT_HOST_WRITE = 2'd1,
    ACT_HOST_READ  = 2'd2,
    ACT_CLEAR_DONE = 2'd3
  } action_t;

  // Bus status decoding
  localparam logic [BYTE_W-1:0] ST_MASK     = 8'hF8;
  localparam logic [BYTE_W-1:0] ST_TX_ADDR  = 8'hA8;  // own address, read
  localparam logic [BYTE_W-1:0] ST_TX_ARB   = 8'hB0;  // arbitration lost, read
  localparam logic [BYTE_W-1:0] ST_TX_DATA  = 8'hB8;  // byte sent, ACK seen
  localparam logic [BYTE_W-1:0] ST_TX_NACK  = 8'hC0;  // byte sent, NACK seen
  localparam logic [BYTE_W-1:0] ST_RX_ADDR  = 8'h60;  // own address, write
  localparam logic [BYTE_W-1:0] ST_RX_ARB   = 8'h68;  // arbitration lost, write
  localparam logic [BYTE_W-1:0] ST_RX_DATA  = 8'h80;  // byte received

  // Per-item result flags from the control stage
  typedef struct packed {
    logic loaded;     // send byte taken from the store
    logic ack;        // ACK next
    logic done;       // done flag after the item
    logic recv;       // receiving flag after the item
    logic host_rd;    // host read of an in-range entry
  } res_flags_t;

endpackage

// ===== hdl/i2cfb_store.sv =====
// ----------------------------------------------------------------------------
// i2cfb_store
// Frame byte store: one write port and one read port with registered data.
// ----------------------------------------------------------------------------
module i2cfb_store
  import i2cfb_pkg::*;
#(
  parameter int DEPTH = 34,
  parameter int AW    = 6
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [BYTE_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [BYTE_W-1:0] rdata
);

  logic [BYTE_W-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/i2cfb_ctrl.sv =====
// ----------------------------------------------------------------------------
// i2cfb_ctrl
// Status decoder and frame state: byte pointer, receiving and done flags and
// a copy of the length byte. Gives one read and at most one write per item.
// ----------------------------------------------------------------------------
module i2cfb_ctrl
  import i2cfb_pkg::*;
#(
  parameter int BUFFER_SIZE = 32,
  parameter int DEPTH       = BUFFER_SIZE + 2,
  parameter int AW          = $clog2(DEPTH),
  parameter int PTR_W       = $clog2(DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  fire,
  input  action_t               action,
  input  logic [BYTE_W-1:0]     status,
  input  logic [BYTE_W-1:0]     bus_byte,
  input  logic [HOST_IDX_W-1:0] host_index,
  input  logic [BYTE_W-1:0]     host_data,
  output logic                  mem_we,
  output logic [AW-1:0]         mem_waddr,
  output logic [BYTE_W-1:0]     mem_wdata,
  output logic [AW-1:0]         mem_raddr,
  output res_flags_t            flags
);

  localparam logic [CMP_W-1:0] HDR_C   = CMP_W'(HDR_BYTES);
  localparam logic [CMP_W-1:0] END_C   = CMP_W'(BUFFER_SIZE + 2);
  localparam logic [31:0]      DEPTH_C = 32'(DEPTH);

  logic [PTR_W-1:0]  ptr, ptr_next;
  logic              recv, recv_next;
  logic              done, done_next;
  logic [BYTE_W-1:0] len, len_next;

  logic [PTR_W-1:0]  ptr_inc;
  logic [BYTE_W-1:0] len_rx;
  logic              end_tx, end_rx;
  logic              idx_ok;
  logic [BYTE_W-1:0] st;

  // Frame end test on the advanced pointer
  function automatic logic frame_end(input logic [PTR_W-1:0] p, input logic [BYTE_W-1:0] l);
    logic [CMP_W-1:0] pw;
    pw = CMP_W'(p);
    return ((pw >= HDR_C) && (pw >= CMP_W'(l) + HDR_C)) || (pw >= END_C);
  endfunction

  assign st      = status & ST_MASK;
  assign ptr_inc = ptr + PTR_W'(1);
  // a received byte at position 1 is the new length
  assign len_rx  = (ptr == PTR_W'(1)) ? bus_byte : len;
  assign end_tx  = frame_end(ptr_inc, len);
  assign end_rx  = frame_end(ptr_inc, len_rx);
  assign idx_ok  = {{(32-HOST_IDX_W){1'b0}}, host_index} < DEPTH_C;

  // Decode one item
  always_comb begin
    ptr_next  = ptr;
    recv_next = recv;
    done_next = done;
    len_next  = len;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = host_data;
    mem_raddr = '0;
    flags     = '0;
    unique case (action)
      ACT_BUS_EVENT: begin
        unique case (st) inside
          ST_TX_ADDR, ST_TX_ARB: begin
            flags.loaded = 1'b1;
            flags.ack    = 1'b1;
            ptr_next     = PTR_W'(1);
          end
          ST_TX_DATA: begin
            mem_raddr    = ptr[AW-1:0];
            flags.loaded = 1'b1;
            flags.ack    = 1'b1;
            ptr_next     = end_tx ? '0 : ptr_inc;
          end
          ST_TX_NACK: begin
            flags.ack = 1'b1;
            ptr_next  = '0;
          end
          ST_RX_ADDR, ST_RX_ARB: begin
            recv_next = 1'b1;
            len_next  = '0;
            mem_we    = 1'b1;
            mem_waddr = AW'(1);
            mem_wdata = '0;
            ptr_next  = '0;
            flags.ack = 1'b1;
          end
          ST_RX_DATA: begin
            mem_we    = 1'b1;
            mem_waddr = ptr[AW-1:0];
            mem_wdata = bus_byte;
            len_next  = len_rx;
            if (end_rx) begin
              recv_next = 1'b0;
              done_next = 1'b1;
              ptr_next  = '0;
            end else begin
              flags.ack = 1'b1;
              ptr_next  = ptr_inc;
            end
          end
          default: begin
            // stop or unexpected status ends reception
            if (!done) begin
              if (recv) begin
                recv_next = 1'b0;
                done_next = 1'b1;
              end else begin
                flags.ack = 1'b1;
              end
              ptr_next = '0;
            end
          end
        endcase
      end
      ACT_HOST_WRITE: begin
        mem_we    = idx_ok;
        mem_waddr = AW'(host_index);
        if (host_index == HOST_IDX_W'(1)) begin
          len_next = host_data;
        end
      end
      ACT_HOST_READ: begin
        mem_raddr     = AW'(host_index);
        flags.host_rd = idx_ok;
      end
      ACT_CLEAR_DONE: begin
        done_next = 1'b0;
      end
      default: begin
        done_next = done;
      end
    endcase
    flags.done = done_next;
    flags.recv = recv_next;
    if (!fire) begin
      mem_we = 1'b0;
    end
  end

  // Frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr  <= '0;
      recv <= 1'b0;
      done <= 1'b0;
    end else if (fire) begin
      ptr  <= ptr_next;
      recv <= recv_next;
      done <= done_next;
    end
  end

  // Length copy, meaningful once byte 1 has been written
  always_ff @(posedge clk) begin
    if (fire) begin
      len <= len_next;
    end
  end

endmodule

// ===== hdl/i2c_slave_frame_buffer_core.sv =====
// ----------------------------------------------------------------------------
// i2c_slave_frame_buffer_core
// I2C slave frame buffer: decodes bus status events and host accesses into
// one result item each.
//
//   Channel | Dir | tdata fields (low bit up)                      | tuser
//   s_      | in  | status, bus_byte, host_index, host_data        | action
//   m_      | out | send_byte, send_loaded, acknowledge,           | -
//           |     | frame_done, host_read_data, receiving_now      |
//
// One item is accepted per cycle while the middle stage can move on.
// Accepting updates the frame state and reads the store into that stage,
// which fills the output register. A result waiting on m_tready leaves
// room for one more item there. Reset clears the pointer, the flags and
// both valid bits; the store has no reset and needs no clearing pass.
// ----------------------------------------------------------------------------
module i2c_slave_frame_buffer_core
  import i2cfb_pkg::*;
#(
  parameter int BUFFER_SIZE = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // status, bus_byte, host_index, host_data
  input  logic [ACTION_W-1:0]  s_tuser,   // action
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata    // send_byte, send_loaded, acknowledge,
                                          // frame_done, host_read_data, receiving_now
);

  localparam int DEPTH = BUFFER_SIZE + 2;
  localparam int AW    = $clog2(DEPTH);
  localparam int PTR_W = $clog2(DEPTH + 1);

  logic                  fire;
  logic                  mid_adv;
  logic                  mid_valid;
  res_flags_t            flags, mid_flags;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr, mem_raddr;
  logic [BYTE_W-1:0]     mem_wdata, rd_data;
  logic [BYTE_W-1:0]     send_byte, host_read_data;
  logic [M_TDATA_W-1:0]  out_next;

  // Handshake
  assign mid_adv  = mid_valid && (!m_tvalid || m_tready);
  assign s_tready = !mid_valid || mid_adv;
  assign fire     = s_tvalid && s_tready;

  i2cfb_ctrl #(
    .BUFFER_SIZE (BUFFER_SIZE),
    .DEPTH       (DEPTH),
    .AW          (AW),
    .PTR_W       (PTR_W)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .action     (action_t'(s_tuser)),
    .status     (s_tdata[7:0]),
    .bus_byte   (s_tdata[15:8]),
    .host_index (s_tdata[21:16]),
    .host_data  (s_tdata[29:22]),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_raddr  (mem_raddr),
    .flags      (flags)
  );

  i2cfb_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (fire),
    .raddr (mem_raddr),
    .rdata (rd_data)
  );

  // Middle stage: flags wait here with the store read data
  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
    end else if (fire) begin
      mid_valid <= 1'b1;
    end else if (mid_adv) begin
      mid_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      mid_flags <= flags;
    end
  end

  // Result packing
  assign send_byte      = mid_flags.loaded  ? rd_data : '0;
  assign host_read_data = mid_flags.host_rd ? rd_data : '0;
  assign out_next = {4'b0, mid_flags.recv, host_read_data, mid_flags.done,
                     mid_flags.ack, mid_flags.loaded, send_byte};

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (mid_adv) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mid_adv) begin
      m_tdata <= out_next;
    end
  end

endmodule

// ===== hdl/i2cfb_chk.sv =====
// ----------------------------------------------------------------------------
// i2cfb_chk
// Port-level checks for the frame buffer core, bound to the top level.
// ----------------------------------------------------------------------------
module i2cfb_chk
  import i2cfb_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [M_TDATA_W-1:0] m_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

  // send byte is zero unless loaded
  a_send_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[8] |-> m_tdata[7:0] == 8'd0)
    else $error("send byte without load");

  // loading a byte always answers ACK
  a_load_ack: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[8] |-> m_tdata[9])
    else $error("loaded byte with NACK");

  // host read data only comes with a host item
  a_hread_only: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[18:11] != 8'd0 |-> !m_tdata[8] && !m_tdata[9])
    else $error("host read data on a bus result");

endmodule

bind i2c_slave_frame_buffer_core i2cfb_chk u_i2cfb_chk (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
